[src/bwtsa_pkg.sv]
// Shared types and constants for the suffix-array to BWT block.
// No dependencies; imported by bwt_from_suffix_array.
`timescale 1ns / 1ps
`default_nettype none

package bwtsa_pkg;

    localparam int DEFAULT_TEXT_DEPTH = 65536;
    localparam int ALPHABET_SIZE      = 256;

    localparam int POS_W        = 16;
    localparam int BYTE_W       = 8;
    localparam int TEXT_LENGTH_W = 17;
    localparam int COUNT_W      = 17;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 17;

    localparam int IN_TDATA_W   = 48;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 40;
    localparam int OUT_TUSER_W  = 1;

    // rank of a queried byte: present bits below it, summed in groups
    localparam int RANK_GROUPS  = 8;
    localparam int RANK_GROUP_W = 32;
    localparam int RANK_PART_W  = 6;
    localparam int RANK_SUM_W   = 9;

    localparam logic [BYTE_W-1:0]  END_MARK  = 8'h24;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

    localparam logic [TEXT_LENGTH_W-1:0] TEXT_LENGTH_RESET = 17'd1;

    localparam logic [CFG_INDEX_W-1:0] REG_TEXT_LENGTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_REVERSE_MODE = 1'b1;

    localparam logic KIND_BWT   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_ENTRY = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

endpackage

`default_nettype wire

[src/bwt_from_suffix_array.sv]
// Channel   | dir | handshake                     | payload
// ----------+-----+-------------------------------+-----------------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tuser: action; tdata: write/entry/query
// m_axis    | out | m_axis_tvalid / m_axis_tready | tuser: result_kind; tdata: result fields
// cfg       | in  | i_cfg_we (no wait)            | i_cfg_index, i_cfg_wdata
//
// Three-stage pipeline: text RAM read, histogram RAM read, histogram write-back.
// One item per cycle is accepted while the output register is free or being taken; the
// output register loads the result from stage 2. The histogram read-modify-write loop sets the rate,
// kept at one item per cycle by forwarding the last written count.
// Reset clears the presence map, which marks which histogram entries are valid.
// The whole pipeline halts while the output register holds a result not yet taken.
// Depends on bwtsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bwt_from_suffix_array
    import bwtsa_pkg::*;
#(
    parameter int TEXT_DEPTH = DEFAULT_TEXT_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // [15:0] text_position, [23:16] text_byte, [39:24] suffix_start, [47:40] query_byte
    input  wire logic [IN_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] action
    input  wire logic [IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // [7:0] bwt_byte, [8] range_error, [25:9] byte_count, [26] byte_present,
    // [34:27] alphabet_index, [39:35] zero
    output logic [OUT_TDATA_W-1:0]        m_axis_tdata,
    // [0] result_kind
    output logic [OUT_TUSER_W-1:0]        m_axis_tuser,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int XW = (AW > TEXT_LENGTH_W) ? AW : TEXT_LENGTH_W;
    localparam logic [TEXT_LENGTH_W-1:0] LEN_CAP =
        (TEXT_DEPTH > 131071) ? 17'h1FFFF : TEXT_LENGTH_W'(TEXT_DEPTH);

    // configuration
    logic [TEXT_LENGTH_W-1:0] r_text_length;
    logic                     r_reverse_mode;

    // memories
    logic [BYTE_W-1:0]  r_text_mem [TEXT_DEPTH];
    logic [COUNT_W-1:0] r_hist_mem [ALPHABET_SIZE];
    logic [BYTE_W-1:0]  r_tq;
    logic [COUNT_W-1:0] r_hq;

    logic [ALPHABET_SIZE-1:0] r_presence;
    logic [ALPHABET_SIZE-1:0] n_presence;

    // stage 1
    logic          r_p1_valid;
    t_action       r_p1_act;
    logic          r_p1_err;
    logic          r_p1_dollar;
    logic          r_p1_count;
    logic [BYTE_W-1:0] r_p1_qbyte;

    // stage 2
    logic              r_p2_valid;
    t_action           r_p2_act;
    logic              r_p2_err;
    logic              r_p2_count;
    logic [BYTE_W-1:0] r_p2_byte;
    logic [RANK_PART_W-1:0] r_p2_part [RANK_GROUPS];

    // histogram forwarding
    logic               r_fwd_hit;
    logic [COUNT_W-1:0] r_fwd_val;

    // output register
    logic                     r_o_valid;
    logic                     r_o_kind;
    logic [BYTE_W-1:0]        r_o_bwt;
    logic                     r_o_err;
    logic [COUNT_W-1:0]       r_o_count;
    logic                     r_o_present;
    logic [BYTE_W-1:0]        r_o_index;

    // input decode
    t_action            in_act;
    logic [POS_W-1:0]   in_pos;
    logic [BYTE_W-1:0]  in_tbyte;
    logic [POS_W-1:0]   in_entry;
    logic [BYTE_W-1:0]  in_qbyte;
    logic               adv;
    logic               accept;
    logic [TEXT_LENGTH_W-1:0] eff_len;
    logic               in_err;
    logic               in_zero;
    logic               pos_ok;
    logic [XW-1:0]      addr_x;
    logic [AW-1:0]      text_addr;
    logic               text_we;

    // stage 1 / 2 logic
    logic [BYTE_W-1:0]        c1;
    logic [BYTE_W-1:0]        hist_raddr;
    logic [ALPHABET_SIZE-1:0] below;
    logic [ALPHABET_SIZE-1:0] masked;
    logic [COUNT_W-1:0]       hq;
    logic [COUNT_W-1:0]       cnt;
    logic [COUNT_W-1:0]       newcnt;
    logic                     p2_result;
    logic                     p2_commit_count;
    logic                     p2_commit_clear;
    logic [RANK_SUM_W-1:0]    rank_sum;

    assign in_act   = t_action'(s_axis_tuser);
    assign in_pos   = s_axis_tdata[15:0];
    assign in_tbyte = s_axis_tdata[23:16];
    assign in_entry = s_axis_tdata[39:24];
    assign in_qbyte = s_axis_tdata[47:40];

    assign adv           = !r_o_valid || m_axis_tready;
    assign s_axis_tready = adv && i_rst_n;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        eff_len = (r_text_length > LEN_CAP) ? LEN_CAP : r_text_length;
        in_err  = {1'b0, in_entry} >= eff_len;
        in_zero = (in_entry == '0);
        pos_ok  = 32'(in_pos) < 32'(TEXT_DEPTH);
        if (in_act == ACT_WRITE) begin
            addr_x = XW'(in_pos);
        end else if (r_reverse_mode) begin
            addr_x = in_zero ? '0 : (XW'(eff_len) - XW'(in_entry));
        end else begin
            addr_x = XW'(in_entry) - XW'(1);
        end
        text_addr = addr_x[AW-1:0];
        text_we   = accept && (in_act == ACT_WRITE) && pos_ok;
    end

    // text store: one write and one read per cycle, the read only while the pipeline advances
    always_ff @(posedge i_clk) begin
        if (text_we) begin
            r_text_mem[text_addr] <= in_tbyte;
        end
        if (adv) begin
            r_tq <= r_text_mem[text_addr];
        end
    end

    // stage 2: count, saturate, presence update, rank sum
    always_comb begin
        hq              = r_fwd_hit ? r_fwd_val : r_hq;
        cnt             = r_presence[r_p2_byte] ? hq : '0;
        newcnt          = (cnt == COUNT_MAX) ? cnt : cnt + COUNT_W'(1);
        p2_result       = r_p2_valid && (r_p2_act == ACT_ENTRY || r_p2_act == ACT_QUERY);
        p2_commit_count = adv && r_p2_valid && r_p2_count;
        p2_commit_clear = adv && r_p2_valid && (r_p2_act == ACT_CLEAR);
        n_presence      = r_presence;
        if (p2_commit_clear) begin
            n_presence = '0;
        end else if (p2_commit_count) begin
            n_presence[r_p2_byte] = 1'b1;
        end
        rank_sum = '0;
        for (int g = 0; g < RANK_GROUPS; g++) begin
            rank_sum = rank_sum + RANK_SUM_W'(r_p2_part[g]);
        end
    end

    // stage 1: resolve the BWT byte, rank partials against the updated map
    always_comb begin
        c1         = r_p1_dollar ? END_MARK : r_tq;
        hist_raddr = (r_p1_act == ACT_QUERY) ? r_p1_qbyte : c1;
        for (int b = 0; b < ALPHABET_SIZE; b++) begin
            below[b] = BYTE_W'(b) < r_p1_qbyte;
        end
        masked = below & n_presence;
    end

    // histogram: read at stage 1, write back at stage 2
    always_ff @(posedge i_clk) begin
        if (p2_commit_count) begin
            r_hist_mem[r_p2_byte] <= newcnt;
        end
        if (adv) begin
            r_hq <= r_hist_mem[hist_raddr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_length  <= TEXT_LENGTH_RESET;
            r_reverse_mode <= 1'b0;
            r_presence     <= '0;
            r_p1_valid     <= 1'b0;
            r_p2_valid     <= 1'b0;
            r_fwd_hit      <= 1'b0;
            r_o_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TEXT_LENGTH:  r_text_length  <= i_cfg_wdata[TEXT_LENGTH_W-1:0];
                    REG_REVERSE_MODE: r_reverse_mode <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            r_presence <= n_presence;
            if (adv) begin
                r_p1_valid <= accept;
                r_p2_valid <= r_p1_valid;
                // the write-back of this edge is not seen by the read of this edge
                r_fwd_hit  <= r_p2_valid && r_p2_count && (hist_raddr == r_p2_byte);
                r_o_valid  <= p2_result;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_act    <= in_act;
            r_p1_err    <= in_err;
            r_p1_dollar <= !r_reverse_mode && in_zero;
            r_p1_count  <= (in_act == ACT_ENTRY) && !r_reverse_mode && !in_err;
            r_p1_qbyte  <= in_qbyte;

            r_p2_act   <= r_p1_act;
            r_p2_err   <= r_p1_err;
            r_p2_count <= r_p1_valid && r_p1_count;
            r_p2_byte  <= hist_raddr;
            for (int g = 0; g < RANK_GROUPS; g++) begin
                r_p2_part[g] <= RANK_PART_W'(
                    $countones(masked[g*RANK_GROUP_W +: RANK_GROUP_W]));
            end

            r_fwd_val <= newcnt;

            if (p2_result) begin
                if (r_p2_act == ACT_QUERY) begin
                    r_o_kind    <= KIND_QUERY;
                    r_o_bwt     <= '0;
                    r_o_err     <= 1'b0;
                    r_o_count   <= cnt;
                    r_o_present <= r_presence[r_p2_byte];
                    r_o_index   <= rank_sum[BYTE_W-1:0];
                end else begin
                    r_o_kind    <= KIND_BWT;
                    r_o_bwt     <= r_p2_err ? '0 : r_p2_byte;
                    r_o_err     <= r_p2_err;
                    r_o_count   <= '0;
                    r_o_present <= 1'b0;
                    r_o_index   <= '0;
                end
            end
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tdata  = {5'd0, r_o_index, r_o_present, r_o_count, r_o_err, r_o_bwt};

`ifndef ASSERT_OFF
    // a counted byte is marked present once written back
    a_count_sets_presence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        p2_commit_count |=> r_presence[$past(r_p2_byte)])
        else $error("counted byte not marked present");

    // a clear empties the presence map
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        p2_commit_clear |=> (r_presence == '0))
        else $error("presence map not cleared");

    // a new result comes only from an entry or query in the last stage
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (!$past(m_axis_tvalid) || $past(m_axis_tready)))
            |-> $past(p2_result && adv))
        else $error("result without a source item");

    // presence and a nonzero count agree in every query answer
    a_present_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_o_kind == KIND_QUERY)) |-> (r_o_present == (r_o_count != '0)))
        else $error("presence and count disagree");
`endif

endmodule

`default_nettype wire
